FILE: rtl/hrmf_pkg.sv
package hrmf_pkg;

    // Line store geometry.
    localparam int MAX_WIDTH      = 2048;
    localparam int COL_W          = 11;
    localparam int MAX_HALF_WIDTH = 15;
    localparam int STORE_ROWS     = 2 * MAX_HALF_WIDTH + 1;
    localparam int SLOT_W         = 5;
    localparam int LS_AW          = SLOT_W + COL_W;

    // Histogram geometry.
    localparam int NUM_BINS   = 65536;
    localparam int BIN_W      = 16;
    localparam int BIN_OFFSET = NUM_BINS / 2 - 1;
    localparam int CNT_W      = 10;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Each histogram entry carries an epoch tag; a stale tag reads as an empty bin.
    localparam int EPOCH_W = 16;
    localparam logic [EPOCH_W-1:0] TAG_NONE   = '1;
    localparam logic [EPOCH_W-1:0] EPOCH_LAST = TAG_NONE - 1'b1;

    // The bin divider retires one quotient bit per cycle.
    localparam int DIV_BITS = 17;
    localparam logic [4:0] DIV_LAST = 5'(DIV_BITS - 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH    = 3'd0,
        REG_HEIGHT   = 3'd1,
        REG_LOW_CUT  = 3'd2,
        REG_HIGH_CUT = 3'd3,
        REG_HALF_X   = 3'd4,
        REG_HALF_Y   = 3'd5,
        REG_STEP     = 3'd6
    } t_cfg_reg;

    typedef enum logic [10:0] {
        S_CLR   = 11'b000_0000_0001,
        S_IDLE  = 11'b000_0000_0010,
        S_TOP   = 11'b000_0000_0100,
        S_RD    = 11'b000_0000_1000,
        S_RDW   = 11'b000_0001_0000,
        S_DIV   = 11'b000_0010_0000,
        S_BRD   = 11'b000_0100_0000,
        S_NEXT  = 11'b000_1000_0000,
        S_SCAN0 = 11'b001_0000_0000,
        S_SCAN  = 11'b010_0000_0000,
        S_RES   = 11'b100_0000_0000
    } t_state;

    typedef struct packed {
        logic              start;
        logic signed [15:0] value;
        logic [14:0]       step;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [BIN_W-1:0] bin;
    } t_div_rsp;

endpackage

FILE: rtl/histogram_running_median_filter_top.sv
// Channel   Handshake            Payload
// input     i_valid / o_ready    i_pixel, i_start_of_frame
// output    o_valid / i_ready    o_median_value, o_window_empty, o_center_row,
//                                o_center_col, o_last_of_frame
// config    i_cfg_we             i_cfg_index, i_cfg_data (no wait, no read-back)
//
// Sequence: one item at a time. A pixel without a window is only accepted. A window pixel
// is accepted and the high cut is divided to the top bin; then each admitted line store
// element is read, bin-divided in 17 steps and its bin updated by read-modify-write,
// and an element outside the cuts is only read: 2*(2*hy+1) elements when the window slides,
// (2*hy+1)*(2*hx+1) at a row start. The median scan is then set up, reads one bin per cycle
// from the lowest bin bound up to the median bin, and the result is registered.
// The single histogram memory port pair and the serial divider keep this work serial.
// Reset: a clearing pass over all 65536 bins follows reset, with o_ready low. Every 65535th
// row start runs the same pass again when the epoch tag wraps.
// Stalls: a finished result waits in the output register while the next item is taken.
module histogram_running_median_filter_top import hrmf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic signed [15:0]    i_pixel,
    input  logic                  i_start_of_frame,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic signed [15:0]    o_median_value,
    output logic                  o_window_empty,
    output logic [15:0]           o_center_row,
    output logic [COL_W-1:0]      o_center_col,
    output logic                  o_last_of_frame,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration registers.
    logic [11:0]        r_cfg_width;
    logic [15:0]        r_cfg_height;
    logic signed [15:0] r_cfg_low;
    logic signed [15:0] r_cfg_high;
    logic [3:0]         r_cfg_hx;
    logic [3:0]         r_cfg_hy;
    logic [14:0]        r_cfg_step;

    // Effective settings after the out-of-range substitutions.
    logic [11:0]        w_eff;
    logic [15:0]        h_eff;
    logic [14:0]        step_eff;
    logic signed [15:0] lo_eff;
    logic [4:0]         twice_hx;
    logic [4:0]         twice_hy;

    assign w_eff    = (r_cfg_width == '0) ? 12'd1 :
                      (r_cfg_width > 12'(MAX_WIDTH)) ? 12'(MAX_WIDTH) : r_cfg_width;
    assign h_eff    = (r_cfg_height == '0) ? 16'd1 : r_cfg_height;
    assign step_eff = (r_cfg_step == '0) ? 15'd1 : r_cfg_step;
    assign lo_eff   = (r_cfg_low == -16'sd32768) ? -16'sd32767 : r_cfg_low;
    assign twice_hx = {r_cfg_hx, 1'b0};
    assign twice_hy = {r_cfg_hy, 1'b0};

    // Memories: the line store holds the last STORE_ROWS rows, one row per slot.
    // A histogram entry is {epoch tag, count}.
    logic [15:0]              mem_ls [2**LS_AW];
    logic [EPOCH_W+CNT_W-1:0] mem_bin [NUM_BINS];
    logic [15:0]              r_ls_q;
    logic [EPOCH_W+CNT_W-1:0] r_bq;

    // Control and item state.
    t_state             r_state;
    logic [16:0]        r_row;
    logic [COL_W-1:0]   r_col;
    logic [SLOT_W-1:0]  r_rslot;
    logic [15:0]        r_it_row;
    logic [COL_W-1:0]   r_it_col;
    logic [SLOT_W-1:0]  r_it_slot;
    logic [SLOT_W-1:0]  r_slot;
    logic [4:0]         r_i;
    logic [4:0]         r_j;
    logic [COL_W-1:0]   r_ecol;
    logic               r_remove;
    logic               r_rebuild;
    logic [BIN_W-1:0]   r_top;
    logic [BIN_W-1:0]   r_bin;
    logic [BIN_W-1:0]   r_lowest;
    logic [CNT_W-1:0]   r_wc;
    logic [EPOCH_W-1:0] r_epoch;
    logic [BIN_W-1:0]   r_clr;
    logic               r_clr_ret;
    logic [BIN_W-1:0]   r_saddr;
    logic [BIN_W-1:0]   r_paddr;
    logic               r_issue;
    logic               r_pend;
    logic [CNT_W:0]     r_kc;
    logic [CNT_W-1:0]   r_klim;
    logic               r_found;
    logic [BIN_W-1:0]   r_fbin;
    t_div_req           r_div_req;
    t_div_rsp           div_rsp;

    // Output register.
    logic               r_ovalid;
    logic signed [15:0] r_o_med;
    logic               r_o_empty;
    logic [15:0]        r_o_row;
    logic [COL_W-1:0]   r_o_col;
    logic               r_o_last;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(STORE_ROWS - 1)) ? '0 : s + 1'b1;
    endfunction

    hrmf_bin_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (r_div_req),
        .o_rsp  (div_rsp)
    );

    // Position bookkeeping for an accepted pixel: the start-of-frame flag and a
    // column beyond a shrunk width are applied first, then the next position.
    logic               accept;
    logic [16:0]        s_row0, s_row1, a_nrow;
    logic [COL_W-1:0]   s_col0, s_col1, a_ncol;
    logic [SLOT_W-1:0]  s_slot0, s_slot1, a_nslot;
    logic               wrap1, wrap2, in_frame, has_win;
    logic [11:0]        c_inc;

    assign accept  = i_valid && (r_state == S_IDLE);
    assign s_row0  = i_start_of_frame ? '0 : r_row;
    assign s_col0  = i_start_of_frame ? '0 : r_col;
    assign s_slot0 = i_start_of_frame ? '0 : r_rslot;
    assign wrap1   = {1'b0, s_col0} >= w_eff;
    assign s_row1  = wrap1 ? s_row0 + 1'b1 : s_row0;
    assign s_col1  = wrap1 ? '0 : s_col0;
    assign s_slot1 = wrap1 ? slot_inc(s_slot0) : s_slot0;
    assign in_frame = s_row1 < {1'b0, h_eff};
    assign c_inc   = {1'b0, s_col1} + 12'd1;
    assign wrap2   = c_inc >= w_eff;
    assign a_ncol  = wrap2 ? '0 : c_inc[COL_W-1:0];
    assign a_nrow  = wrap2 ? s_row1 + 1'b1 : s_row1;
    assign a_nslot = wrap2 ? slot_inc(s_slot1) : s_slot1;
    assign has_win = (s_row1 >= 17'(twice_hy)) && (s_col1 >= COL_W'(twice_hx));

    // First line store slot of the window: (row - 2*hy) mod STORE_ROWS.
    logic [SLOT_W:0]   slot_diff;
    logic [SLOT_W-1:0] slot_first;
    assign slot_diff  = {1'b0, r_it_slot} - {1'b0, twice_hy};
    assign slot_first = slot_diff[SLOT_W] ? SLOT_W'(slot_diff + (SLOT_W+1)'(STORE_ROWS))
                                          : slot_diff[SLOT_W-1:0];

    // Histogram entry as read; a stale epoch tag is an empty bin.
    logic [CNT_W-1:0] bq_cnt;
    logic [CNT_W:0]   kc_sum;
    logic [CNT_W-1:0] upd_cnt;
    assign bq_cnt  = (r_bq[EPOCH_W+CNT_W-1:CNT_W] == r_epoch) ? r_bq[CNT_W-1:0] : '0;
    assign kc_sum  = r_kc + {1'b0, bq_cnt};
    assign upd_cnt = r_remove ? ((bq_cnt != '0) ? bq_cnt - 1'b1 : bq_cnt)
                              : ((bq_cnt != CNT_MAX) ? bq_cnt + 1'b1 : bq_cnt);

    logic signed [15:0] ls_val;
    logic               admitted;
    assign ls_val   = $signed(r_ls_q);
    assign admitted = (ls_val >= lo_eff) && (ls_val <= r_cfg_high);

    // Result arithmetic.
    logic signed [17:0] fbin_s;
    logic signed [33:0] prod;
    assign fbin_s = $signed({2'b00, r_fbin}) - 18'sd32767;
    assign prod   = fbin_s * $signed({1'b0, step_eff});

    // Memory ports.
    logic               ls_we;
    logic               bin_we;
    logic [BIN_W-1:0]   bin_waddr;
    logic [EPOCH_W+CNT_W-1:0] bin_wdata;
    logic [BIN_W-1:0]   bin_raddr;

    assign ls_we     = accept && in_frame;
    assign bin_we    = (r_state == S_BRD) || (r_state == S_CLR);
    assign bin_waddr = (r_state == S_CLR) ? r_clr : r_bin;
    assign bin_wdata = (r_state == S_CLR) ? {TAG_NONE, {CNT_W{1'b0}}} : {r_epoch, upd_cnt};
    assign bin_raddr = (r_state == S_SCAN) ? r_saddr : div_rsp.bin;

    always_ff @(posedge i_clk) begin
        if (ls_we) begin
            mem_ls[{s_slot1, s_col1}] <= i_pixel;
        end
        r_ls_q <= mem_ls[{r_slot, r_ecol}];
    end

    always_ff @(posedge i_clk) begin
        if (bin_we) begin
            mem_bin[bin_waddr] <= bin_wdata;
        end
        r_bq <= mem_bin[bin_raddr];
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= 12'd2048;
            r_cfg_height <= 16'd2048;
            r_cfg_low    <= -16'sd32767;
            r_cfg_high   <= 16'sd32767;
            r_cfg_hx     <= 4'd1;
            r_cfg_hy     <= 4'd1;
            r_cfg_step   <= 15'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_WIDTH:    r_cfg_width  <= i_cfg_data[11:0];
                REG_HEIGHT:   r_cfg_height <= i_cfg_data;
                REG_LOW_CUT:  r_cfg_low    <= $signed(i_cfg_data);
                REG_HIGH_CUT: r_cfg_high   <= $signed(i_cfg_data);
                REG_HALF_X:   r_cfg_hx     <= i_cfg_data[3:0];
                REG_HALF_Y:   r_cfg_hy     <= i_cfg_data[3:0];
                REG_STEP:     r_cfg_step   <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr     <= '0;
            r_clr_ret <= 1'b0;
            r_epoch   <= '0;
            r_row     <= '0;
            r_col     <= '0;
            r_rslot   <= '0;
            r_wc      <= '0;
            r_lowest  <= BIN_W'(NUM_BINS - 1);
            r_ovalid  <= 1'b0;
            r_div_req <= '0;
            r_issue   <= 1'b0;
            r_pend    <= 1'b0;
        end else begin
            r_div_req.start <= 1'b0;
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == '1) begin
                        r_state <= r_clr_ret ? S_RD : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        if (in_frame) begin
                            r_row     <= a_nrow;
                            r_col     <= a_ncol;
                            r_rslot   <= a_nslot;
                            r_it_row  <= s_row1[15:0];
                            r_it_col  <= s_col1;
                            r_it_slot <= s_slot1;
                            if (has_win) begin
                                r_div_req <= '{start: 1'b1, value: r_cfg_high, step: step_eff};
                                r_state   <= S_TOP;
                            end
                        end else begin
                            r_row   <= s_row1;
                            r_col   <= s_col1;
                            r_rslot <= s_slot1;
                        end
                    end
                end
                S_TOP: begin
                    if (div_rsp.done) begin
                        r_top     <= div_rsp.bin;
                        r_slot    <= slot_first;
                        r_i       <= '0;
                        r_j       <= '0;
                        r_rebuild <= (r_it_col == COL_W'(twice_hx));
                        if (r_it_col == COL_W'(twice_hx)) begin
                            // Row start: empty the histogram by moving to a new epoch.
                            r_ecol   <= '0;
                            r_remove <= 1'b0;
                            r_wc     <= '0;
                            r_lowest <= div_rsp.bin;
                            if (r_epoch == EPOCH_LAST) begin
                                r_epoch   <= '0;
                                r_clr     <= '0;
                                r_clr_ret <= 1'b1;
                                r_state   <= S_CLR;
                            end else begin
                                r_epoch <= r_epoch + 1'b1;
                                r_state <= S_RD;
                            end
                        end else begin
                            r_ecol   <= r_it_col - COL_W'(twice_hx) - 1'b1;
                            r_remove <= 1'b1;
                            r_state  <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_RDW;
                end
                S_RDW: begin
                    if (admitted) begin
                        r_div_req <= '{start: 1'b1, value: ls_val, step: step_eff};
                        r_state   <= S_DIV;
                    end else begin
                        r_state <= S_NEXT;
                    end
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        r_bin   <= div_rsp.bin;
                        r_state <= S_BRD;
                    end
                end
                S_BRD: begin
                    if (r_remove) begin
                        if (r_wc != '0) begin
                            r_wc <= r_wc - 1'b1;
                        end
                    end else begin
                        if (r_wc != CNT_MAX) begin
                            r_wc <= r_wc + 1'b1;
                        end
                        if (r_bin <= r_lowest) begin
                            r_lowest <= r_bin;
                        end
                    end
                    r_state <= S_NEXT;
                end
                S_NEXT: begin
                    r_state <= S_RD;
                    if (r_rebuild) begin
                        if (r_j < twice_hx) begin
                            r_j    <= r_j + 1'b1;
                            r_ecol <= r_ecol + 1'b1;
                        end else begin
                            r_j    <= '0;
                            r_ecol <= '0;
                            if (r_i < twice_hy) begin
                                r_i    <= r_i + 1'b1;
                                r_slot <= slot_inc(r_slot);
                            end else begin
                                r_state <= S_SCAN0;
                            end
                        end
                    end else if (r_remove) begin
                        r_remove <= 1'b0;
                        r_ecol   <= r_it_col;
                    end else if (r_i < twice_hy) begin
                        r_i      <= r_i + 1'b1;
                        r_slot   <= slot_inc(r_slot);
                        r_remove <= 1'b1;
                        r_ecol   <= r_it_col - COL_W'(twice_hx) - 1'b1;
                    end else begin
                        r_state <= S_SCAN0;
                    end
                end
                S_SCAN0: begin
                    r_kc    <= '0;
                    r_klim  <= (r_wc >> 1) + 1'b1;
                    r_saddr <= r_lowest;
                    r_pend  <= 1'b0;
                    if ((r_wc == '0) || (r_lowest > r_top)) begin
                        r_found <= 1'b0;
                        r_state <= S_RES;
                    end else begin
                        r_issue <= 1'b1;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // One bin is read per cycle; its count is summed in the next cycle.
                    r_pend  <= r_issue;
                    r_paddr <= r_saddr;
                    if (r_issue) begin
                        if (r_saddr == r_top) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_saddr <= r_saddr + 1'b1;
                        end
                    end
                    if (r_pend) begin
                        r_kc <= kc_sum;
                        if (kc_sum >= {1'b0, r_klim}) begin
                            r_found <= 1'b1;
                            r_fbin  <= r_paddr;
                            r_issue <= 1'b0;
                            r_state <= S_RES;
                        end else if (r_paddr == r_top) begin
                            r_found <= 1'b0;
                            r_issue <= 1'b0;
                            r_state <= S_RES;
                        end
                    end
                end
                S_RES: begin
                    if (!r_ovalid || i_ready) begin
                        r_ovalid  <= 1'b1;
                        r_o_med   <= r_found ? prod[15:0] : 16'sd0;
                        r_o_empty <= !r_found;
                        r_o_row   <= r_it_row - 16'(r_cfg_hy);
                        r_o_col   <= r_it_col - COL_W'(r_cfg_hx);
                        r_o_last  <= (r_it_row == h_eff - 1'b1) &&
                                     ({1'b0, r_it_col} == w_eff - 1'b1);
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = r_ovalid;
    assign o_median_value  = r_o_med;
    assign o_window_empty  = r_o_empty;
    assign o_center_row    = r_o_row;
    assign o_center_col    = r_o_col;
    assign o_last_of_frame = r_o_last;

endmodule

FILE: rtl/hrmf_bin_div.sv
module hrmf_bin_div import hrmf_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic             r_busy;
    logic [4:0]       r_cnt;
    logic             r_neg;
    logic [16:0]      r_dvd;
    logic [14:0]      r_rem;
    logic [14:0]      r_step;
    logic             r_done;
    logic [BIN_W-1:0] r_bin;

    logic [15:0]        trial;
    logic               ge;
    logic [15:0]        diff;
    logic [16:0]        quo_next;
    logic signed [17:0] q_signed;
    logic signed [17:0] idx;
    logic [16:0]        mag;

    // Restoring division of the magnitude, one bit per cycle.
    assign trial    = {r_rem, r_dvd[16]};
    assign ge       = trial >= {1'b0, r_step};
    assign diff     = trial - {1'b0, r_step};
    assign quo_next = {r_dvd[15:0], ge};
    assign q_signed = r_neg ? -$signed({1'b0, quo_next}) : $signed({1'b0, quo_next});
    assign idx      = q_signed + 18'(BIN_OFFSET);
    assign mag      = i_req.value[15] ? 17'(-{i_req.value[15], i_req.value})
                                      : {1'b0, i_req.value};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_neg  <= i_req.value[15];
                r_dvd  <= mag;
                r_rem  <= '0;
                r_step <= i_req.step;
            end else if (r_busy) begin
                r_rem <= ge ? diff[14:0] : trial[14:0];
                r_dvd <= quo_next;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_bin  <= idx[17] ? '0 : idx[BIN_W-1:0];
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.bin  = r_bin;

endmodule

FILE: rtl/hrmf_chk.sv
module hrmf_chk import hrmf_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  o_ready,
    input logic signed [15:0]    i_pixel,
    input logic                  i_start_of_frame,
    input logic                  o_valid,
    input logic                  i_ready,
    input logic signed [15:0]    o_median_value,
    input logic                  o_window_empty,
    input logic [15:0]           o_center_row,
    input logic [COL_W-1:0]      o_center_col,
    input logic                  o_last_of_frame,
    input logic                  i_cfg_we,
    input logic [CFG_IDX_W-1:0]  i_cfg_index,
    input logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Reset leaves no result pending and starts the clearing pass.
    assert property (@(posedge i_clk) !i_rst_n |=> !o_valid && !o_ready)
        else $error("result or ready right after reset");

    // An empty window always reports a zero median.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_window_empty |-> o_median_value == 16'sd0)
        else $error("empty window with nonzero median");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped before it was taken");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_median_value) && $stable(o_center_row)
                                && $stable(o_center_col))
        else $error("stalled result changed");

endmodule

bind histogram_running_median_filter_top hrmf_chk u_hrmf_chk (.*);

FILE: verif/histogram_running_median_filter_checker.sv
module histogram_running_median_filter_checker import hrmf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic                  i_o_ready,
    input  logic signed [15:0]    i_pixel,
    input  logic                  i_start_of_frame,
    input  logic                  i_o_valid,
    input  logic                  i_ready,
    input  logic signed [15:0]    i_median_value,
    input  logic                  i_window_empty,
    input  logic [15:0]           i_center_row,
    input  logic [COL_W-1:0]      i_center_col,
    input  logic                  i_last_of_frame,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [15:0] median;
        logic               empty;
        logic [15:0]        row;
        logic [COL_W-1:0]   col;
        logic               last;
    } median_t;

    median_t expected_medians[$];

    logic [15:0] line_store [STORE_ROWS*MAX_WIDTH];
    int          bin_counts [int];
    int          window_count;
    int          lowest_bin;
    int          row_pos;
    int          col_pos;

    logic [11:0] cfg_width;
    logic [15:0] cfg_height;
    logic [15:0] cfg_low;
    logic [15:0] cfg_high;
    logic [3:0]  cfg_hx;
    logic [3:0]  cfg_hy;
    logic [14:0] cfg_step;

    int lo_cut, hi_cut, step_val;

    assign o_pending = expected_medians.size();

    function automatic int bin_index(int v);
        int idx;
        idx = v / step_val + BIN_OFFSET;
        if (idx < 0) idx = 0;
        if (idx > NUM_BINS - 1) idx = NUM_BINS - 1;
        return idx;
    endfunction

    function automatic int stored(int row, int col);
        return int'($signed(line_store[(row % STORE_ROWS) * MAX_WIDTH + col]));
    endfunction

    function automatic void admit(int v);
        int b;
        if (v < lo_cut || v > hi_cut) return;
        b = bin_index(v);
        if (!bin_counts.exists(b)) bin_counts[b] = 0;
        if (bin_counts[b] < 1023) bin_counts[b]++;
        if (window_count < 1023) window_count++;
        if (b <= lowest_bin) lowest_bin = b;
    endfunction

    function automatic void drop(int v);
        int b;
        if (v < lo_cut || v > hi_cut) return;
        b = bin_index(v);
        if (bin_counts.exists(b) && bin_counts[b] > 0) bin_counts[b]--;
        if (window_count > 0) window_count--;
    endfunction

    // Advances the filter by one pixel; returns 1 when a window completes.
    function automatic bit filter_pixel(logic signed [15:0] pix, logic sof, output median_t res);
        int w, h, hx, hy, r, c, top, klim, kc, fbin, med;
        bit found;
        w = int'(cfg_width);
        h = int'(cfg_height);
        hx = int'(cfg_hx);
        hy = int'(cfg_hy);
        found = 0;
        fbin = 0;
        med = 0;
        if (w == 0) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        if (h == 0) h = 1;
        if (hx > MAX_HALF_WIDTH) hx = MAX_HALF_WIDTH;
        if (hy > MAX_HALF_WIDTH) hy = MAX_HALF_WIDTH;
        step_val = (cfg_step == 0) ? 1 : int'(cfg_step);
        lo_cut = int'($signed(cfg_low));
        if (lo_cut < -32767) lo_cut = -32767;
        hi_cut = int'($signed(cfg_high));

        if (sof) begin
            row_pos = 0;
            col_pos = 0;
        end
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h) return 0;
        r = row_pos;
        c = col_pos;
        line_store[(r % STORE_ROWS) * MAX_WIDTH + c] = pix;
        col_pos = c + 1;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos = r + 1;
        end
        if (r < 2 * hy || c < 2 * hx) return 0;

        if (c == 2 * hx) begin
            bin_counts.delete();
            window_count = 0;
            lowest_bin = bin_index(hi_cut);
            for (int k = r - 2 * hy; k <= r; k++)
                for (int j = 0; j <= 2 * hx; j++) admit(stored(k, j));
        end else begin
            for (int k = r - 2 * hy; k <= r; k++) begin
                drop(stored(k, c - 2 * hx - 1));
                admit(stored(k, c));
            end
        end

        if (window_count > 0) begin
            top = bin_index(hi_cut);
            klim = window_count / 2 + 1;
            kc = 0;
            foreach (bin_counts[k]) begin
                if (!found && k >= lowest_bin && k <= top) begin
                    kc += bin_counts[k];
                    if (kc >= klim) begin
                        found = 1;
                        fbin = k;
                    end
                end
            end
        end
        if (found) med = (fbin - BIN_OFFSET) * step_val;
        res.median = med[15:0];
        res.empty  = !found;
        res.row    = 16'(r - hy);
        res.col    = COL_W'(c - hx);
        res.last   = (r == h - 1) && (c == w - 1);
        return 1;
    endfunction

    initial begin
        foreach (line_store[i]) line_store[i] = '0;
    end

    always @(posedge i_clk) begin
        median_t res, got;
        if (!i_rst_n) begin
            bin_counts.delete();
            window_count = 0;
            lowest_bin = NUM_BINS - 1;
            row_pos = 0;
            col_pos = 0;
            cfg_width = 12'd2048;
            cfg_height = 16'd2048;
            cfg_low = 16'(-32767);
            cfg_high = 16'd32767;
            cfg_hx = 4'd1;
            cfg_hy = 4'd1;
            cfg_step = 15'd1;
            o_fail_count = 0;
            expected_medians.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_index))
                    REG_WIDTH:    cfg_width  = i_cfg_data[11:0];
                    REG_HEIGHT:   cfg_height = i_cfg_data;
                    REG_LOW_CUT:  cfg_low    = i_cfg_data;
                    REG_HIGH_CUT: cfg_high   = i_cfg_data;
                    REG_HALF_X:   cfg_hx     = i_cfg_data[3:0];
                    REG_HALF_Y:   cfg_hy     = i_cfg_data[3:0];
                    REG_STEP:     cfg_step   = i_cfg_data[14:0];
                    default: ;
                endcase
            end
            if (i_valid && i_o_ready) begin
                if (filter_pixel(i_pixel, i_start_of_frame, res)) expected_medians.push_back(res);
            end
            if (i_o_valid && i_ready) begin
                got.median = i_median_value;
                got.empty  = i_window_empty;
                got.row    = i_center_row;
                got.col    = i_center_col;
                got.last   = i_last_of_frame;
                if (expected_medians.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected result: median %0d empty %0b row %0d col %0d last %0b",
                                 got.median, got.empty, got.row, got.col, got.last);
                end else begin
                    res = expected_medians.pop_front();
                    if (got.median !== res.median || got.empty !== res.empty ||
                        got.row !== res.row || got.col !== res.col || got.last !== res.last) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display({"mismatch: expected median %0d empty %0b row %0d col %0d ",
                                      "last %0b, got median %0d empty %0b row %0d col %0d last %0b"},
                                     res.median, res.empty, res.row, res.col, res.last,
                                     got.median, got.empty, got.row, got.col, got.last);
                    end
                end
            end
        end
    end

endmodule

FILE: verif/histogram_running_median_filter_top_test.sv
module histogram_running_median_filter_top_test;
    import hrmf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // The run is ended by force if it goes past this many cycles. The costliest window pixel
    // is a full rebuild of the largest window followed by a scan over every bin, and the
    // figure covers every item of the run at that cost.
    localparam int CYCLE_LIMIT = 400_000_000;
    localparam int RANDOM_ITEMS = 1250;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic signed [15:0]    i_pixel = '0;
    logic                  i_start_of_frame = 1'b0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic signed [15:0]    o_median_value;
    logic                  o_window_empty;
    logic [15:0]           o_center_row;
    logic [COL_W-1:0]      o_center_col;
    logic                  o_last_of_frame;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int fail_count;
    int pending_medians;
    int cycle_count = 0;
    int pixels_sent = 0;

    histogram_running_median_filter_top dut (.*);

    histogram_running_median_filter_checker median_checker (
        .i_clk, .i_rst_n, .i_valid, .i_o_ready(o_ready), .i_pixel, .i_start_of_frame,
        .i_o_valid(o_valid), .i_ready, .i_median_value(o_median_value),
        .i_window_empty(o_window_empty), .i_center_row(o_center_row),
        .i_center_col(o_center_col), .i_last_of_frame(o_last_of_frame),
        .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending_medians)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake must not keep the run alive forever.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // The result side lowers ready for a randomly drawn gap before it takes each item. When the draw is
    // zero, ready simply stays high so that back-to-back items are taken.
    initial begin
        int gap;
        @(posedge i_clk);
        forever begin
            gap = $urandom_range(0, 3);
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // Writes one register; the caller lowers the write enable after the last write.
    task automatic write_reg(t_cfg_reg index, int value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= 16'(value);
        @(posedge i_clk);
    endtask

    task automatic set_filter(int width, int height, int low, int high, int hx, int hy,
                              int step);
        write_reg(REG_WIDTH, width);
        write_reg(REG_HEIGHT, height);
        write_reg(REG_LOW_CUT, low);
        write_reg(REG_HIGH_CUT, high);
        write_reg(REG_HALF_X, hx);
        write_reg(REG_HALF_Y, hy);
        write_reg(REG_STEP, step);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // The sender idles for a randomly drawn gap before each item, then holds it until it is taken.
    task automatic send_pixel(int value, bit sof);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_pixel          <= 16'(value);
        i_start_of_frame <= sof;
        do @(posedge i_clk); while (!o_ready);
        pixels_sent++;
    endtask

    // Registers may only change once the block has gone quiet. A pixel that yields no
    // result is only accepted and leaves the block idle, so a short pause after the last result suffices.
    task automatic drain();
        i_valid <= 1'b0;
        while (pending_medians != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    function automatic int clamp16(int v);
        if (v < -32768) return -32768;
        if (v > 32767) return 32767;
        return v;
    endfunction

    // Sends one frame of pixels clustered around a center. Now and then a pixel is
    // pure noise or, with extremes set, an extreme, the frame restarts in the middle,
    // or stray pixels follow the frame's last pixel.
    task automatic run_frame(int width, int height, int center, int spread, bit extremes);
        int total, v;
        total = width * height;
        for (int i = 0; i < total; i++) begin
            v = clamp16(center + $urandom_range(0, 2 * spread) - spread);
            if ($urandom_range(0, 99) < 3) v = clamp16($urandom_range(0, 65535) - 32768);
            if (extremes && $urandom_range(0, 99) < 5)
                v = $urandom_range(0, 1) ? 32767 : -32768;
            send_pixel(v, (i == 0) || ($urandom_range(0, 199) == 0));
        end
        if ($urandom_range(0, 99) < 30)
            repeat ($urandom_range(1, 3)) send_pixel($urandom_range(0, 65535) - 32768, 1'b0);
    endtask

    initial begin
        int width, height, wi, hi_rows, hx, hy, step, center, spread, low, high, sel;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: a tiny 4x3 image with the extremes of the pixel range, including the
        // most negative value, which the low cut can never admit.
        set_filter(4, 3, -32768, 32767, 1, 1, 1);
        send_pixel(-32768, 1'b1);
        send_pixel(32767, 1'b0);
        send_pixel(-32767, 1'b0);
        send_pixel(0, 1'b0);
        send_pixel(-1, 1'b0);
        send_pixel(1, 1'b0);
        send_pixel(32767, 1'b0);
        send_pixel(-32767, 1'b0);
        send_pixel(100, 1'b0);
        send_pixel(-100, 1'b0);
        send_pixel(5, 1'b0);
        send_pixel(7, 1'b0);
        // Past the last row: ignored until the next start of frame.
        send_pixel(12345, 1'b0);
        drain();

        // Crossed cuts: every window is empty.
        set_filter(3, 3, 100, -100, 1, 1, 3);
        for (int i = 0; i < 9; i++) send_pixel(i * 10 - 40, i == 0);
        drain();

        // Zero width, height and step act as one; a 1x1 window on a single pixel.
        set_filter(0, 0, -32767, 32767, 0, 0, 0);
        send_pixel(-32767, 1'b1);
        send_pixel(32767, 1'b1);
        drain();

        // An oversized width acts as the maximum, and a full-range height.
        set_filter(4095, 65535, -32767, 32767, 0, 0, 32767);
        send_pixel(32767, 1'b1);
        send_pixel(-32767, 1'b0);
        send_pixel(16384, 1'b0);
        drain();

        // Largest window with the coarsest step on a 31x31 image, which has room for one window.
        set_filter(31, 31, -32767, 32767, 15, 15, 32767);
        run_frame(31, 31, 0, 32767, 1'b1);
        drain();

        // Random phases, each with its own settings and one frame.
        while (pixels_sent < RANDOM_ITEMS) begin
            wi = $urandom_range(0, 12);
            hi_rows = $urandom_range(0, 6);
            if ($urandom_range(0, 9) == 0) wi = $urandom_range(13, 40);
            hx = $urandom_range(0, 3);
            hy = $urandom_range(0, 2);
            sel = $urandom_range(0, 9);
            if (sel < 4) step = $urandom_range(0, 8);
            else if (sel < 8) step = $urandom_range(9, 2000);
            else step = $urandom_range(2001, 32767);
            width = (wi == 0) ? 1 : wi;
            height = (hi_rows == 0) ? 1 : hi_rows;
            center = $urandom_range(0, 65535) - 32768;
            spread = ((step == 0) ? 1 : step) * 48;
            if (spread > 20000) spread = 20000;
            sel = $urandom_range(0, 9);
            if (sel < 5) begin
                low = -32767;
                high = 32767;
            end else if (sel < 8) begin
                low = clamp16(center - spread / 2);
                high = clamp16(center + spread / 2);
                if (low < -32767) low = -32767;
            end else if (sel < 9) begin
                low = clamp16(center + spread / 4 + 1);
                high = clamp16(center - spread / 4);
            end else begin
                low = -32768;
                high = $urandom_range(0, 32767);
            end
            set_filter(wi, hi_rows, low, high, hx, hy, step);
            run_frame(width, height, center, spread, step >= 512);
            drain();
        end

        while (pending_medians != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && pending_medians == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/hrmf_pkg.sv
rtl/hrmf_bin_div.sv
rtl/histogram_running_median_filter_top.sv
rtl/hrmf_chk.sv
verif/histogram_running_median_filter_checker.sv
verif/histogram_running_median_filter_top_test.sv
